// ----- rtl/rec_pkg.sv -----
// ----------------------------------------------------------------------------
// rec_pkg: shared types and codes for the reference-counted entry cache
// Beat structs, table entry layout, op/status codes, shared-unit modes.
// ----------------------------------------------------------------------------
package rec_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = 10;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [7:0]       dev_t;
	typedef logic [15:0]      obj_t;
	typedef logic [5:0]       slot_t;
	typedef logic [1:0]       op_t;
	typedef logic [2:0]       status_t;
	typedef logic [1:0]       unit_mode_t;

	localparam cnt_t COUNT_MAX = {CNT_W{1'b1}};

	localparam op_t OP_GET  = 2'd0;
	localparam op_t OP_DUP  = 2'd1;
	localparam op_t OP_PUT  = 2'd2;
	localparam op_t OP_MARK = 2'd3;

	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_NEW      = 3'd1;
	localparam status_t ST_FULL     = 3'd2;
	localparam status_t ST_FREE_PUT = 3'd3;
	localparam status_t ST_SAT      = 3'd4;

	localparam unit_mode_t U_HOLD = 2'd0;
	localparam unit_mode_t U_INC  = 2'd1;
	localparam unit_mode_t U_DEC  = 2'd2;

	typedef struct packed {
		op_t   op;
		dev_t  device;
		obj_t  object_number;
		slot_t slot_index;
	} req_t;

	typedef struct packed {
		slot_t   slot;
		status_t status;
		cnt_t    ref_count;
		logic    needs_load;
	} rsp_t;

	typedef struct packed {
		dev_t key_device;
		obj_t key_object;
		cnt_t refs;
		logic valid;
	} entry_t;

	typedef struct packed {
		logic key_eq;
		logic zero;
		logic sat;
		cnt_t count;
	} unit_res_t;

	function automatic idx_t to_idx(input slot_t s);
		return IDX_W'(s);
	endfunction

endpackage

// ----- rtl/refcounted_entry_cache.sv -----
// A get reads the slots in order from slot 0 until a hit or the last slot, so
// a hit ends the scan early; dup/put/mark work on the named slot alone.
// Throughput: one request at a time; busy stays high until the result beat,
// set by the single table read port walked one slot per cycle.
// Reset clears all counts and valid flags at once via per-slot written bits.
// Result is a one-cycle done strobe; the receiver cannot stall it.
// ----------------------------------------------------------------------------
// refcounted_entry_cache: reference-counted entry cache, top level
// Sequencer over the slot table and the shared compare/count unit.
// ----------------------------------------------------------------------------
module refcounted_entry_cache import rec_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_RMW  = 2'd2;

	localparam idx_t LAST = IDX_W'(ENTRIES - 1);

	logic [1:0] state_q, state_d;
	logic       done_q, done_d;
	logic       have_free_q, have_free_d;
	req_t       req_q, req_d;
	logic       oor_q, oor_d;
	idx_t       addr_q, addr_d;
	idx_t       free_q, free_d;
	rsp_t       rsp_q, rsp_d;

	logic       rd_en;
	idx_t       rd_addr;
	entry_t     ent;
	logic       we;
	idx_t       wr_addr;
	entry_t     wr_data;
	unit_mode_t mode;
	unit_res_t  ures;

	logic       hit;
	logic       free_now;
	idx_t       fslot;
	logic       hf;

	rec_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (ent),
		.we      (we),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	rec_unit u_unit (
		.mode          (mode),
		.ent           (ent),
		.device        (req_q.device),
		.object_number (req_q.object_number),
		.res           (ures)
	);

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	assign hit      = !ures.zero && ures.key_eq;
	assign free_now = !have_free_q && ures.zero;
	assign fslot    = free_now ? addr_q : free_q;
	assign hf       = have_free_q || free_now;

	always_comb begin
		mode = U_HOLD;
		if (state_q == S_SCAN) begin
			mode = U_INC;
		end else if (state_q == S_RMW) begin
			if (req_q.op == OP_DUP) mode = U_INC;
			else if (req_q.op == OP_PUT) mode = U_DEC;
		end
	end

	always_comb begin
		state_d     = state_q;
		done_d      = 1'b0;
		have_free_d = have_free_q;
		req_d       = req_q;
		oor_d       = oor_q;
		addr_d      = addr_q;
		free_d      = free_q;
		rsp_d       = rsp_q;
		rd_en       = 1'b0;
		rd_addr     = addr_q;
		we          = 1'b0;
		wr_addr     = addr_q;
		wr_data     = ent;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					req_d       = req;
					have_free_d = 1'b0;
					oor_d       = (32'(req.slot_index) >= ENTRIES);
					if (req.op == OP_GET) begin
						rd_en   = 1'b1;
						rd_addr = '0;
						addr_d  = '0;
						state_d = S_SCAN;
					end else begin
						rd_en   = !(32'(req.slot_index) >= ENTRIES);
						rd_addr = to_idx(req.slot_index);
						addr_d  = to_idx(req.slot_index);
						state_d = S_RMW;
					end
				end
			end
			S_SCAN: begin
				if (hit) begin
					we               = 1'b1;
					wr_data.refs     = ures.count;
					rsp_d.slot       = slot_t'(addr_q);
					rsp_d.status     = ures.sat ? ST_SAT : ST_OK;
					rsp_d.ref_count  = ures.count;
					rsp_d.needs_load = !ent.valid;
					done_d           = 1'b1;
					state_d          = S_IDLE;
				end else if (addr_q == LAST) begin
					if (hf) begin
						// claim lowest free slot
						we                 = 1'b1;
						wr_addr            = fslot;
						wr_data.key_device = req_q.device;
						wr_data.key_object = req_q.object_number;
						wr_data.refs       = cnt_t'(1);
						wr_data.valid      = 1'b0;
						rsp_d.slot         = slot_t'(fslot);
						rsp_d.status       = ST_NEW;
						rsp_d.ref_count    = cnt_t'(1);
						rsp_d.needs_load   = 1'b1;
					end else begin
						rsp_d.slot       = '0;
						rsp_d.status     = ST_FULL;
						rsp_d.ref_count  = '0;
						rsp_d.needs_load = 1'b0;
					end
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					rd_en       = 1'b1;
					rd_addr     = addr_q + idx_t'(1);
					addr_d      = addr_q + idx_t'(1);
					free_d      = fslot;
					have_free_d = hf;
				end
			end
			S_RMW: begin
				rsp_d.slot = req_q.slot_index;
				if (oor_q) begin
					rsp_d.status     = ST_FREE_PUT;
					rsp_d.ref_count  = '0;
					rsp_d.needs_load = 1'b1;
				end else begin
					rsp_d.needs_load = !ent.valid;
					unique case (req_q.op)
						OP_DUP: begin
							we              = 1'b1;
							wr_data.refs    = ures.count;
							rsp_d.status    = ures.sat ? ST_SAT : ST_OK;
							rsp_d.ref_count = ures.count;
						end
						OP_PUT: begin
							we              = !ures.zero;
							wr_data.refs    = ures.count;
							rsp_d.status    = ures.zero ? ST_FREE_PUT : ST_OK;
							rsp_d.ref_count = ures.count;
						end
						OP_MARK: begin
							we               = 1'b1;
							wr_data.valid    = 1'b1;
							rsp_d.status     = ST_OK;
							rsp_d.ref_count  = ent.refs;
							rsp_d.needs_load = 1'b0;
						end
						OP_GET: begin
							rsp_d.status    = ST_OK;
							rsp_d.ref_count = ent.refs;
						end
					endcase
				end
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_q      <= 1'b0;
			have_free_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			done_q      <= done_d;
			have_free_q <= have_free_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q  <= req_d;
		oor_q  <= oor_d;
		addr_q <= addr_d;
		free_q <= free_d;
		rsp_q  <= rsp_d;
	end

`ifndef NO_ASSERTIONS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while still busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted request did not enter a work state");

	a_full_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_FULL) |-> (rsp.ref_count == '0 && rsp.slot == '0))
		else $error("full-table result carries a slot or count");

	a_new_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_NEW) |-> (rsp.ref_count == cnt_t'(1) && rsp.needs_load))
		else $error("newly claimed slot reported with wrong count or load flag");
`endif

endmodule

// ----- rtl/rec_store.sv -----
// ----------------------------------------------------------------------------
// rec_store: slot table
// One write port, one registered read port. Per-slot written bits make an
// untouched slot read back with count zero and valid clear.
// ----------------------------------------------------------------------------
module rec_store import rec_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   rd_en,
	input  idx_t   rd_addr,
	output entry_t rd_data,
	input  logic   we,
	input  idx_t   wr_addr,
	input  entry_t wr_data
);

	entry_t             mem [ENTRIES];
	entry_t             rd_q;
	logic [ENTRIES-1:0] touched_q;
	logic               rd_touched_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touched_q    <= '0;
			rd_touched_q <= 1'b0;
		end else begin
			if (we) begin
				touched_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_touched_q <= touched_q[rd_addr];
			end
		end
	end

	always_comb begin
		rd_data = rd_q;
		if (!rd_touched_q) begin
			rd_data.refs  = '0;
			rd_data.valid = 1'b0;
		end
	end

endmodule

// ----- rtl/rec_unit.sv -----
// ----------------------------------------------------------------------------
// rec_unit: shared compare and count unit
// Key compare, zero test and saturating increment / decrement of one count.
// ----------------------------------------------------------------------------
module rec_unit import rec_pkg::*; (
	input  unit_mode_t mode,
	input  entry_t     ent,
	input  dev_t       device,
	input  obj_t       object_number,
	output unit_res_t  res
);

	always_comb begin
		res.key_eq = (ent.key_device == device) && (ent.key_object == object_number);
		res.zero   = (ent.refs == '0);
		res.sat    = (ent.refs == COUNT_MAX);
		res.count  = ent.refs;
		unique case (mode)
			U_INC: begin
				if (!res.sat) res.count = ent.refs + cnt_t'(1);
			end
			U_DEC: begin
				if (!res.zero) res.count = ent.refs - cnt_t'(1);
			end
			default: res.count = ent.refs;
		endcase
	end

endmodule
